// ===== rtl/csl_pkg.sv =====
// csl_pkg: shared types, token kind codes, character classes and saturating helpers
// for the C subset lexer. No dependencies; used by csl_ctrl, csl_dp and c_subset_lexer.

package csl_pkg;

  localparam int CHAR_LA_MAX = 6;   // a char literal is settled after at most six bytes
  localparam int LINE_W      = 16;
  localparam int COL_W       = 16;
  localparam int LEN_W       = 16;
  localparam int OUT_OFF_W   = 24;
  localparam int KIND_W      = 4;

  typedef logic [7:0] byte_t;

  localparam logic [KIND_W-1:0] K_IDENT  = 4'd0;
  localparam logic [KIND_W-1:0] K_INT    = 4'd1;
  localparam logic [KIND_W-1:0] K_CHAR   = 4'd2;
  localparam logic [KIND_W-1:0] K_STRING = 4'd3;
  localparam logic [KIND_W-1:0] K_OP     = 4'd4;
  localparam logic [KIND_W-1:0] K_SEMI   = 4'd5;
  localparam logic [KIND_W-1:0] K_LPAREN = 4'd6;
  localparam logic [KIND_W-1:0] K_RPAREN = 4'd7;
  localparam logic [KIND_W-1:0] K_LBRACE = 4'd8;
  localparam logic [KIND_W-1:0] K_RBRACE = 4'd9;
  localparam logic [KIND_W-1:0] K_COMMA  = 4'd10;
  localparam logic [KIND_W-1:0] K_BAD    = 4'd11;
  localparam logic [KIND_W-1:0] K_UNTERM = 4'd12;

  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SQ    = 8'h27;
  localparam byte_t CH_DQ    = 8'h22;
  localparam byte_t CH_BS    = 8'h5C;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_STAR  = 8'h2A;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_STR, M_STR_ESC, M_SLASH,
    M_LINE, M_BLOCK, M_BLOCK_STAR, M_CHAR
  } scan_mode_t;

  typedef enum logic [1:0] {
    C_WAIT, C_RUN, C_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;      // take the input item into the byte queue
    logic step_en;   // lex one byte or one end-of-source flush
    logic finish;    // close the item: last token out, clear on end of source
  } csl_cmd_t;

  typedef struct packed {
    logic busy;      // bytes queued or an open token at end of source
    logic emit_req;  // this step produces a token
    logic pend_v;    // a token waits in the hold register
    logic out_free;  // output register can take a token this cycle
  } csl_sts_t;

  function automatic logic is_alpha(byte_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(byte_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(byte_t c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_lineterm(byte_t c);
    return c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic is_esc(byte_t c);
    return c == "b" || c == "t" || c == "n" || c == "v" || c == "f" || c == "r" ||
           c == CH_SQ || c == CH_BS || c == CH_DQ || (c >= "0" && c <= "7");
  endfunction

  // single-byte tokens; anything unlisted is a bad byte
  function automatic logic [KIND_W-1:0] punct_kind(byte_t c);
    logic [KIND_W-1:0] k;
    unique case (c)
      "+", "-", "*", "=": k = K_OP;
      ";":                k = K_SEMI;
      "(":                k = K_LPAREN;
      ")":                k = K_RPAREN;
      "{":                k = K_LBRACE;
      "}":                k = K_RBRACE;
      ",":                k = K_COMMA;
      default:            k = K_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sat_add16(logic [15:0] a, logic [2:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {14'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ===== rtl/csl_ctrl.sv =====
// csl_ctrl: sequencer for the C subset lexer. Accepts an item, steps the datapath
// until its byte queue drains, then closes the item. Depends on csl_pkg.

module csl_ctrl
  import csl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  csl_sts_t sts,
  output csl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        no_stall;

  assign no_stall = !(sts.emit_req && sts.pend_v && !sts.out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_WAIT: begin
        if (in_tvalid) state_nxt = C_RUN;
      end
      C_RUN: begin
        if (!sts.busy) state_nxt = C_DONE;
      end
      C_DONE: begin
        if (!sts.pend_v || sts.out_free) state_nxt = C_WAIT;
      end
      default: state_nxt = C_WAIT;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.step_en = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state_r)
      C_WAIT: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      C_RUN: begin
        cmd.step_en = sts.busy && no_stall;
      end
      C_DONE: begin
        cmd.finish = !sts.pend_v || sts.out_free;
      end
      default: ;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step_en, cmd.finish}))
    else $error("csl_ctrl: more than one command at once");

  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == C_RUN)
    else $error("csl_ctrl: accepted item did not start lexing");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_en |-> !(sts.emit_req && sts.pend_v && !sts.out_free))
    else $error("csl_ctrl: token emitted with hold and output both full");

endmodule

// ===== rtl/csl_dp.sv =====
// csl_dp: lexer datapath - scan mode, position counters, char literal lookahead,
// replay byte queue, token hold register and output register. Depends on csl_pkg.

module csl_dp
  import csl_pkg::*;
#(
  parameter int LOOKAHEAD_DEPTH = 6,
  parameter int OFFSET_BITS     = 24
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  csl_cmd_t             cmd,
  output csl_sts_t             sts,
  input  byte_t                in_byte,
  input  logic                 in_eoi,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [LINE_W-1:0]    out_line,
  output logic [COL_W-1:0]     out_col,
  output logic [OUT_OFF_W-1:0] out_off,
  output logic [LEN_W-1:0]     out_len,
  output logic                 out_last
);

  localparam int QCW = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  scan_mode_t             mode_r, mode_nxt;
  logic [LINE_W-1:0]      cur_line_r, cur_line_nxt, tok_line_r, tok_line_nxt;
  logic [COL_W-1:0]       cur_col_r, cur_col_nxt, tok_col_r, tok_col_nxt;
  logic [OFFSET_BITS-1:0] cur_off_r, cur_off_nxt, tok_off_r, tok_off_nxt;
  logic [LEN_W-1:0]       tok_len_r, tok_len_nxt;
  logic [QCW-1:0]         la_fill_r, la_fill_nxt, q_cnt_r, q_cnt_nxt;
  logic [QCW-1:0]         chk_n, rq_cnt;
  byte_t                  la_r [LOOKAHEAD_DEPTH];
  byte_t                  chk_b [LOOKAHEAD_DEPTH];
  byte_t                  q_r [LOOKAHEAD_DEPTH];
  byte_t                  q_nxt [LOOKAHEAD_DEPTH];
  byte_t                  rq [LOOKAHEAD_DEPTH];
  logic                   eoi_r;

  logic                   pend_v_r;
  logic [KIND_W-1:0]      pend_kind_r;
  logic [LINE_W-1:0]      pend_line_r;
  logic [COL_W-1:0]       pend_col_r;
  logic [OFFSET_BITS-1:0] pend_off_r;
  logic [LEN_W-1:0]       pend_len_r;

  logic                   out_v_r, out_last_r;
  logic [KIND_W-1:0]      out_kind_r;
  logic [LINE_W-1:0]      out_line_r;
  logic [COL_W-1:0]       out_col_r;
  logic [OFFSET_BITS-1:0] out_off_r;
  logic [LEN_W-1:0]       out_len_r;

  byte_t                  c;
  logic                   feeding, flushing, app, consume, emit, ck_do;
  logic [KIND_W-1:0]      emit_kind;
  logic [LINE_W-1:0]      adv_line;
  logic [COL_W-1:0]       adv_col;
  logic [OFFSET_BITS:0]   off_inc, off_rew;
  logic [OFFSET_BITS-1:0] adv_off;

  // char literal check results
  logic                   ck_res;
  logic [KIND_W-1:0]      ck_kind;
  logic [2:0]             ck_cons;
  logic [2:0]             ck_from;

  logic                   out_free, mv_step, mv_fin;

  assign c        = q_r[0];
  assign feeding  = q_cnt_r != '0;
  assign flushing = !feeding && eoi_r && mode_r != M_IDLE;
  assign app      = feeding && mode_r == M_CHAR &&
                    int'(la_fill_r) < LOOKAHEAD_DEPTH;
  assign chk_n    = app ? la_fill_r + QCW'(1) : la_fill_r;
  assign out_free = !out_v_r || out_ready;

  // next position after consuming c
  assign off_inc  = {1'b0, cur_off_r} + {{OFFSET_BITS{1'b0}}, 1'b1};
  assign adv_off  = off_inc[OFFSET_BITS] ? OFF_MAX : off_inc[OFFSET_BITS-1:0];
  assign adv_line = (c == CH_LF) ? sat_add16(cur_line_r, 3'd1) : cur_line_r;
  assign adv_col  = (c == CH_LF) ? COL_W'(1) : sat_add16(cur_col_r, 3'd1);
  assign off_rew  = {1'b0, tok_off_r} + {{(OFFSET_BITS-2){1'b0}}, ck_cons};

  always_comb begin
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      chk_b[i] = (app && int'(la_fill_r) == i) ? c : la_r[i];
    end
  end

  // char literal decision over the buffered bytes
  always_comb begin
    int   n;
    logic esc_last;
    logic e1, e2, e3, e4;
    n        = int'(chk_n);
    esc_last = 1'b0;
    for (int i = 0; i < CHAR_LA_MAX; i++) begin
      if (n == i + 1 && is_esc(chk_b[i])) esc_last = 1'b1;
    end
    e1 = is_esc(chk_b[1]);
    e2 = e1 && is_esc(chk_b[2]);
    e3 = e2 && is_esc(chk_b[3]);
    e4 = e3 && is_esc(chk_b[4]);
    ck_res  = 1'b1;
    ck_kind = K_BAD;
    ck_cons = 3'd1;
    ck_from = 3'd0;
    priority if (n < 2) begin
      ck_res = flushing || n == 0 || is_lineterm(chk_b[0]);
    end else if (!is_lineterm(chk_b[0]) && chk_b[1] == CH_SQ) begin
      ck_kind = K_CHAR; ck_cons = 3'd3; ck_from = 3'd2;
    end else if (chk_b[0] != CH_BS) begin
      ck_kind = K_BAD;
    end else if (!flushing && n < CHAR_LA_MAX && esc_last) begin
      ck_res = 1'b0;
    end else if (n > 5 && chk_b[5] == CH_SQ && e4) begin
      ck_kind = K_CHAR; ck_cons = 3'd7; ck_from = 3'd6;
    end else if (n > 4 && chk_b[4] == CH_SQ && e3) begin
      ck_kind = K_CHAR; ck_cons = 3'd6; ck_from = 3'd5;
    end else if (n > 3 && chk_b[3] == CH_SQ && e2) begin
      ck_kind = K_CHAR; ck_cons = 3'd5; ck_from = 3'd4;
    end else if (n > 2 && chk_b[2] == CH_SQ && e1) begin
      ck_kind = K_CHAR; ck_cons = 3'd4; ck_from = 3'd3;
    end else begin
      ck_kind = K_BAD;
    end
  end

  assign ck_do = (feeding || flushing) && mode_r == M_CHAR && ck_res;

  // one byte of the scan, or one end-of-source flush
  always_comb begin
    mode_nxt     = mode_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    cur_off_nxt  = cur_off_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_off_nxt  = tok_off_r;
    tok_len_nxt  = tok_len_r;
    la_fill_nxt  = la_fill_r;
    consume      = 1'b0;
    emit         = 1'b0;
    emit_kind    = K_BAD;
    if (feeding) begin
      unique case (mode_r)
        M_IDENT, M_INT: begin
          if (is_digit(c) || (mode_r == M_IDENT && is_alpha(c))) begin
            tok_len_nxt = sat_add16(tok_len_r, 3'd1);
            consume = 1'b1;
          end else begin
            emit = 1'b1; emit_kind = (mode_r == M_IDENT) ? K_IDENT : K_INT;
            mode_nxt = M_IDLE;
          end
        end
        M_STR: begin
          if (c == CH_LF) begin
            emit = 1'b1; emit_kind = K_UNTERM; mode_nxt = M_IDLE;
          end else begin
            tok_len_nxt = sat_add16(tok_len_r, 3'd1);
            consume = 1'b1;
            if (c == CH_DQ) begin
              emit = 1'b1; emit_kind = K_STRING; mode_nxt = M_IDLE;
            end else if (c == CH_BS) begin
              mode_nxt = M_STR_ESC;
            end
          end
        end
        M_STR_ESC: begin
          if (is_lineterm(c)) begin
            emit = 1'b1; emit_kind = K_UNTERM; mode_nxt = M_IDLE;
          end else begin
            tok_len_nxt = sat_add16(tok_len_r, 3'd1);
            consume = 1'b1;
            mode_nxt = M_STR;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = M_LINE; consume = 1'b1;
          end else if (c == CH_STAR) begin
            mode_nxt = M_BLOCK; consume = 1'b1;
          end else begin
            emit = 1'b1; emit_kind = K_OP; mode_nxt = M_IDLE;
          end
        end
        M_LINE: begin
          if (c == CH_LF) mode_nxt = M_IDLE;
          consume = 1'b1;
        end
        M_BLOCK: begin
          if (c == CH_STAR) mode_nxt = M_BLOCK_STAR;
          consume = 1'b1;
        end
        M_BLOCK_STAR: begin
          if (c == CH_SLASH) mode_nxt = M_IDLE;
          else if (c != CH_STAR) mode_nxt = M_BLOCK;
          consume = 1'b1;
        end
        M_CHAR: begin
          la_fill_nxt = chk_n;
        end
        default: begin
          consume = 1'b1;
          if (!is_space(c)) begin
            tok_line_nxt = cur_line_r;
            tok_col_nxt  = cur_col_r;
            tok_off_nxt  = cur_off_r;
            tok_len_nxt  = LEN_W'(1);
            priority if (is_alpha(c)) begin
              mode_nxt = M_IDENT;
            end else if (is_digit(c)) begin
              mode_nxt = M_INT;
            end else if (c == CH_DQ) begin
              mode_nxt = M_STR;
            end else if (c == CH_SLASH) begin
              mode_nxt = M_SLASH;
            end else if (c == CH_SQ) begin
              mode_nxt = M_CHAR; la_fill_nxt = '0;
            end else begin
              emit = 1'b1; emit_kind = punct_kind(c); mode_nxt = M_IDLE;
            end
          end
        end
      endcase
      if (consume) begin
        cur_line_nxt = adv_line;
        cur_col_nxt  = adv_col;
        cur_off_nxt  = adv_off;
      end
      // char bytes wait in the lookahead and move no counter
      if (mode_r == M_CHAR) consume = 1'b1;
    end else if (flushing) begin
      unique case (mode_r)
        M_IDENT:           begin emit = 1'b1; emit_kind = K_IDENT;  end
        M_INT:             begin emit = 1'b1; emit_kind = K_INT;    end
        M_STR, M_STR_ESC:  begin emit = 1'b1; emit_kind = K_UNTERM; end
        M_SLASH:           begin emit = 1'b1; emit_kind = K_OP;     end
        default: ;
      endcase
      if (mode_r != M_CHAR) mode_nxt = M_IDLE;
    end
    if (ck_do) begin
      emit         = 1'b1;
      emit_kind    = ck_kind;
      mode_nxt     = M_IDLE;
      tok_len_nxt  = LEN_W'(ck_cons);
      cur_line_nxt = tok_line_r;
      cur_col_nxt  = sat_add16(tok_col_r, ck_cons);
      cur_off_nxt  = off_rew[OFFSET_BITS] ? OFF_MAX : off_rew[OFFSET_BITS-1:0];
      la_fill_nxt  = '0;
    end
  end

  // byte queue: shift on consume, or put the unused lookahead bytes in front
  always_comb begin
    int rn;
    int fr;
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      rq[i] = feeding ? q_r[(i + 1) % LOOKAHEAD_DEPTH] : q_r[i];
    end
    rq_cnt = feeding ? q_cnt_r - QCW'(1) : q_cnt_r;
    rn     = int'(chk_n) - int'(ck_from);
    fr     = int'(ck_from);
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      q_nxt[i] = (consume && !ck_do) ? rq[i] : q_r[i];
      if (ck_do) begin
        q_nxt[i] = rq[0];
        for (int j = 0; j < LOOKAHEAD_DEPTH; j++) begin
          if (i < rn && j == fr + i) q_nxt[i] = chk_b[j];
          if (i >= rn && j == i - rn) q_nxt[i] = rq[j];
        end
      end
    end
    if (ck_do) q_cnt_nxt = rq_cnt + QCW'(rn);
    else if (consume) q_cnt_nxt = rq_cnt;
    else q_cnt_nxt = q_cnt_r;
  end

  assign mv_step = cmd.step_en && emit && pend_v_r;
  assign mv_fin  = cmd.finish && pend_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      cur_line_r <= LINE_W'(1);
      cur_col_r  <= COL_W'(1);
      cur_off_r  <= '0;
      tok_line_r <= LINE_W'(1);
      tok_col_r  <= COL_W'(1);
      tok_off_r  <= '0;
      tok_len_r  <= '0;
      la_fill_r  <= '0;
      q_cnt_r    <= '0;
      eoi_r      <= 1'b0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        q_cnt_r <= QCW'(1);
        eoi_r   <= in_eoi;
      end else if (cmd.step_en) begin
        mode_r     <= mode_nxt;
        cur_line_r <= cur_line_nxt;
        cur_col_r  <= cur_col_nxt;
        cur_off_r  <= cur_off_nxt;
        tok_line_r <= tok_line_nxt;
        tok_col_r  <= tok_col_nxt;
        tok_off_r  <= tok_off_nxt;
        tok_len_r  <= tok_len_nxt;
        la_fill_r  <= la_fill_nxt;
        q_cnt_r    <= q_cnt_nxt;
      end else if (cmd.finish && eoi_r) begin
        // end of source: back to the reset state for the next source
        mode_r     <= M_IDLE;
        cur_line_r <= LINE_W'(1);
        cur_col_r  <= COL_W'(1);
        cur_off_r  <= '0;
        tok_line_r <= LINE_W'(1);
        tok_col_r  <= COL_W'(1);
        tok_off_r  <= '0;
        tok_len_r  <= '0;
        la_fill_r  <= '0;
      end
      if (cmd.step_en && emit) pend_v_r <= 1'b1;
      else if (cmd.finish) pend_v_r <= 1'b0;
      if (mv_step || mv_fin) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) q_r[0] <= in_byte;
    else if (cmd.step_en) q_r <= q_nxt;
    if (app && cmd.step_en) la_r <= chk_b;
    if (cmd.step_en && emit) begin
      pend_kind_r <= emit_kind;
      pend_line_r <= tok_line_nxt;
      pend_col_r  <= tok_col_nxt;
      pend_off_r  <= tok_off_nxt;
      pend_len_r  <= tok_len_nxt;
    end
    if (mv_step || mv_fin) begin
      out_kind_r <= pend_kind_r;
      out_line_r <= pend_line_r;
      out_col_r  <= pend_col_r;
      out_off_r  <= pend_off_r;
      out_len_r  <= pend_len_r;
      out_last_r <= mv_fin;
    end
  end

  assign sts.busy     = feeding || flushing;
  assign sts.emit_req = emit;
  assign sts.pend_v   = pend_v_r;
  assign sts.out_free = out_free;

  assign out_valid = out_v_r;
  assign out_kind  = out_kind_r;
  assign out_line  = out_line_r;
  assign out_col   = out_col_r;
  assign out_off   = OUT_OFF_W'(out_off_r);
  assign out_len   = out_len_r;
  assign out_last  = out_last_r;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(q_cnt_r) <= LOOKAHEAD_DEPTH)
    else $error("csl_dp: replay queue overflow");

  a_la_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(la_fill_r) <= CHAR_LA_MAX)
    else $error("csl_dp: char lookahead past its limit");

  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && eoi_r |=> mode_r == M_IDLE && q_cnt_r == '0 && la_fill_r == '0)
    else $error("csl_dp: state not cleared at end of source");

  a_no_lost_token: assert property (@(posedge clk) disable iff (!rst_n)
    mv_step || mv_fin |-> out_free)
    else $error("csl_dp: token overwrote an untaken output");

endmodule

// ===== rtl/c_subset_lexer.sv =====
// c_subset_lexer: top level of the streaming C subset lexer.
// Instantiates csl_ctrl (sequencer) and csl_dp (datapath); depends on csl_pkg.
//
//   port group | dir | tdata                  | tuser      | tlast
//   in_        | in  | source byte            | -          | end of source
//   out_       | out | line,col,offset,length | token kind | last token of the item
//
// An item goes through the wait, run and done states, with one scan step per byte lexed
// and one per token that closes on a following byte; a char literal that fails or
// overreaches replays up to 6 buffered bytes, one a cycle unless the output stalls,
// through the same scan step. End of source adds one flush step per open token, then
// all state returns to reset. Results go through a hold register and an output register;
// a stalled out_tready holds the scan only when both are full. Reset (rst_n low, synchronous) empties both.

module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int LOOKAHEAD_DEPTH = 6,
  parameter int OFFSET_BITS     = 24
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] start_line, [31:16] start_column, [55:32] start_offset, [71:56] token_length
  output logic [71:0] out_tdata,
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_of_run
);

  csl_cmd_t               cmd;
  csl_sts_t               sts;
  logic [LINE_W-1:0]      line;
  logic [COL_W-1:0]       col;
  logic [OUT_OFF_W-1:0]   off;
  logic [LEN_W-1:0]       len;

  csl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csl_dp #(
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_tdata),
    .in_eoi    (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_line  (line),
    .out_col   (col),
    .out_off   (off),
    .out_len   (len),
    .out_last  (out_tlast)
  );

  assign out_tdata = {len, off, col, line};

endmodule
